/* rtl/core/ktcd_pkg.sv */
package ktcd_pkg;

  localparam int KeyW = 32;
  localparam int SlotKeyW = 31;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_COMPACT = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BADARG = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef logic [4:0] ktcd_op_t;

  localparam ktcd_op_t OP_NONE = 5'd0;
  localparam ktcd_op_t OP_LOAD = 5'd1;
  localparam ktcd_op_t OP_INSERT = 5'd2;
  localparam ktcd_op_t OP_RD = 5'd3;
  localparam ktcd_op_t OP_IDX_INC = 5'd4;
  localparam ktcd_op_t OP_SRCH_HIT = 5'd5;
  localparam ktcd_op_t OP_CF_HIT = 5'd6;
  localparam ktcd_op_t OP_IDX_ZERO = 5'd7;
  localparam ktcd_op_t OP_PUSH = 5'd8;
  localparam ktcd_op_t OP_POP_RD = 5'd9;
  localparam ktcd_op_t OP_POP_LD = 5'd10;
  localparam ktcd_op_t OP_E_INC = 5'd11;
  localparam ktcd_op_t OP_F_DEC = 5'd12;
  localparam ktcd_op_t OP_CP_RD = 5'd13;
  localparam ktcd_op_t OP_CP_WR = 5'd14;
  localparam ktcd_op_t OP_FIN = 5'd15;
  localparam ktcd_op_t OP_DONE = 5'd16;

  typedef struct packed {
    logic [1:0] cmd;
    logic       key_pos;
    logic       idx_end;
    logic       match_key;
    logic       match_par;
    logic       sp_zero;
    logic       sp_full;
    logic       e_end;
    logic       e_valid;
    logic       f_valid;
    logic       f_le_e;
  } ktcd_flags_t;

endpackage

/* rtl/core/ktcd_ctrl.sv */
module ktcd_ctrl
  import ktcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  ktcd_flags_t flags,
  output ktcd_op_t    op,
  output logic        busy
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INS = 4'd1;
  localparam logic [3:0] S_SR_RD = 4'd2;
  localparam logic [3:0] S_SR_CK = 4'd3;
  localparam logic [3:0] S_CF_RD = 4'd4;
  localparam logic [3:0] S_CF_CK = 4'd5;
  localparam logic [3:0] S_CS_RD = 4'd6;
  localparam logic [3:0] S_CS_CK = 4'd7;
  localparam logic [3:0] S_POP_LD = 4'd8;
  localparam logic [3:0] S_CE = 4'd9;
  localparam logic [3:0] S_CFD = 4'd10;
  localparam logic [3:0] S_CWR = 4'd11;
  localparam logic [3:0] S_CE2 = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op = OP_LOAD;
          case (flags.cmd)
            CMD_INSERT: state_nxt = S_INS;
            CMD_REMOVE: state_nxt = flags.key_pos ? S_CF_RD : S_DONE;
            CMD_SEARCH: state_nxt = flags.key_pos ? S_SR_RD : S_DONE;
            default: state_nxt = S_CE;
          endcase
        end
      end
      S_INS: begin
        op = OP_INSERT;
        state_nxt = S_DONE;
      end
      S_SR_RD: begin
        if (flags.idx_end) begin
          state_nxt = S_DONE;
        end else begin
          op = OP_RD;
          state_nxt = S_SR_CK;
        end
      end
      S_SR_CK: begin
        if (flags.match_key) begin
          op = OP_SRCH_HIT;
          state_nxt = S_DONE;
        end else begin
          op = OP_IDX_INC;
          state_nxt = S_SR_RD;
        end
      end
      S_CF_RD: begin
        if (flags.idx_end) begin
          op = OP_IDX_ZERO;
          state_nxt = S_CS_RD;
        end else begin
          op = OP_RD;
          state_nxt = S_CF_CK;
        end
      end
      S_CF_CK: begin
        if (flags.match_key) begin
          op = OP_CF_HIT;
          state_nxt = S_CS_RD;
        end else begin
          op = OP_IDX_INC;
          state_nxt = S_CF_RD;
        end
      end
      S_CS_RD: begin
        if (flags.idx_end) begin
          if (flags.sp_zero) begin
            state_nxt = S_DONE;
          end else begin
            op = OP_POP_RD;
            state_nxt = S_POP_LD;
          end
        end else begin
          op = OP_RD;
          state_nxt = S_CS_CK;
        end
      end
      S_CS_CK: begin
        // on a matching child with stack room, descend into it: save where the scan stands
        if (flags.match_par && !flags.sp_full) begin
          op = OP_PUSH;
          state_nxt = S_CF_RD;
        end else begin
          op = OP_IDX_INC;
          state_nxt = S_CS_RD;
        end
      end
      S_POP_LD: begin
        op = OP_POP_LD;
        state_nxt = S_CS_RD;
      end
      S_CE: begin
        if (flags.e_end) begin
          state_nxt = S_DONE;
        end else if (flags.e_valid) begin
          op = OP_E_INC;
        end else begin
          state_nxt = S_CFD;
        end
      end
      S_CFD: begin
        if (flags.f_le_e) begin
          op = OP_FIN;
          state_nxt = S_DONE;
        end else if (!flags.f_valid) begin
          op = OP_F_DEC;
        end else begin
          op = OP_CP_RD;
          state_nxt = S_CWR;
        end
      end
      S_CWR: begin
        op = OP_CP_WR;
        state_nxt = S_CE2;
      end
      S_CE2: begin
        if (flags.e_end || !flags.e_valid) begin
          state_nxt = S_CFD;
        end else begin
          op = OP_E_INC;
        end
      end
      S_DONE: begin
        op = OP_DONE;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/ktcd_dp.sv */
module ktcd_dp
  import ktcd_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int HANDLE_WIDTH = 16,
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ktcd_op_t                op,
  output ktcd_flags_t             flags,
  input  logic [1:0]              in_command,
  input  logic [KeyW-1:0]         in_entry_key,
  input  logic [KeyW-1:0]         in_parent_key,
  input  logic [HANDLE_WIDTH-1:0] in_data_handle,
  output logic                    out_strobe,
  output logic [1:0]              out_status,
  output logic [SlotKeyW-1:0]     out_found_key,
  output logic [SlotKeyW-1:0]     out_found_parent,
  output logic [HANDLE_WIDTH-1:0] out_found_data,
  output logic [CW-1:0]           out_removed_count,
  output logic [CW-1:0]           out_entry_count
);

  localparam int SlotW = 2 * SlotKeyW + HANDLE_WIDTH;
  localparam int StkW = SlotKeyW + IW;
  localparam logic [CW-1:0] Depth = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] One = CW'(1);

  logic [SlotW-1:0] slot_mem [TABLE_DEPTH];
  logic [StkW-1:0]  stk_mem [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [CW-1:0] fill_r, sp_r, idx_r, e_r, f_r, removed_r;
  logic [1:0] cmd_r, status_r;
  logic [KeyW-1:0] key_r, par_r;
  logic [HANDLE_WIDTH-1:0] data_r;
  logic [SlotKeyW-1:0] cur_r;
  logic [SlotKeyW-1:0] fk_r, fp_r;
  logic [HANDLE_WIDTH-1:0] fd_r;
  logic [SlotW-1:0] rd_q;
  logic [StkW-1:0] stk_q;
  logic strobe_r;
  logic [1:0] o_status_r;
  logic [SlotKeyW-1:0] o_fk_r, o_fp_r;
  logic [HANDLE_WIDTH-1:0] o_fd_r;
  logic [CW-1:0] o_rem_r, o_cnt_r;

  logic [SlotKeyW-1:0] rd_key, rd_par;
  logic [HANDLE_WIDTH-1:0] rd_data;
  logic full, badarg;
  logic mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [SlotW-1:0] mem_wd;

  assign rd_key = rd_q[SlotW-1 -: SlotKeyW];
  assign rd_par = rd_q[HANDLE_WIDTH +: SlotKeyW];
  assign rd_data = rd_q[HANDLE_WIDTH-1:0];

  assign full = (fill_r == Depth);
  assign badarg = key_r[KeyW-1] || (key_r == '0) || par_r[KeyW-1];

  assign flags.cmd = in_command;
  assign flags.key_pos = !in_entry_key[KeyW-1] && (in_entry_key != '0);
  assign flags.idx_end = (idx_r >= fill_r);
  assign flags.match_key = valid_r[idx_r[IW-1:0]] && (rd_key == cur_r);
  assign flags.match_par = valid_r[idx_r[IW-1:0]] && (rd_par == cur_r);
  assign flags.sp_zero = (sp_r == '0);
  assign flags.sp_full = (sp_r == Depth);
  assign flags.e_end = (e_r >= fill_r);
  assign flags.e_valid = valid_r[e_r[IW-1:0]];
  assign flags.f_valid = valid_r[f_r[IW-1:0]];
  assign flags.f_le_e = (f_r <= e_r);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = fill_r[IW-1:0];
    mem_wd = {key_r[SlotKeyW-1:0], par_r[SlotKeyW-1:0], data_r};
    if (op == OP_INSERT) begin
      mem_we = !full && !badarg;
    end else if (op == OP_CP_WR) begin
      mem_we = 1'b1;
      mem_wa = e_r[IW-1:0];
      mem_wd = rd_q;
    end
  end

  assign mem_ra = (op == OP_CP_RD) ? f_r[IW-1:0] : idx_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (op == OP_RD || op == OP_CP_RD) begin
      rd_q <= slot_mem[mem_ra];
    end
    if (op == OP_PUSH) begin
      stk_mem[sp_r[IW-1:0]] <= {cur_r, idx_r[IW-1:0]};
    end
    if (op == OP_POP_RD) begin
      stk_q <= stk_mem[sp_r[IW-1:0] - IW'(1)];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r <= '0;
      sp_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (op == OP_DONE);
      case (op)
        OP_LOAD: sp_r <= '0;
        OP_INSERT: begin
          if (!full && !badarg) begin
            valid_r[fill_r[IW-1:0]] <= 1'b1;
            fill_r <= fill_r + One;
          end
        end
        OP_CF_HIT: valid_r[idx_r[IW-1:0]] <= 1'b0;
        OP_PUSH: sp_r <= sp_r + One;
        OP_POP_RD: sp_r <= sp_r - One;
        OP_CP_WR: begin
          valid_r[e_r[IW-1:0]] <= 1'b1;
          valid_r[f_r[IW-1:0]] <= 1'b0;
        end
        OP_FIN: fill_r <= e_r;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        cmd_r <= in_command;
        key_r <= in_entry_key;
        par_r <= in_parent_key;
        data_r <= in_data_handle;
        cur_r <= in_entry_key[SlotKeyW-1:0];
        idx_r <= '0;
        e_r <= '0;
        f_r <= fill_r - One;
        removed_r <= '0;
        fk_r <= '0;
        fp_r <= '0;
        fd_r <= '0;
        if (in_command == CMD_SEARCH) begin
          status_r <= flags.key_pos ? ST_NOTFOUND : ST_BADARG;
        end else begin
          status_r <= ST_OK;
        end
      end
      OP_INSERT: begin
        if (full) begin
          status_r <= ST_FULL;
        end else if (badarg) begin
          status_r <= ST_BADARG;
        end
      end
      OP_IDX_INC: idx_r <= idx_r + One;
      OP_IDX_ZERO: idx_r <= '0;
      OP_SRCH_HIT: begin
        status_r <= ST_OK;
        fk_r <= rd_key;
        fp_r <= rd_par;
        fd_r <= rd_data;
      end
      OP_CF_HIT: begin
        removed_r <= removed_r + One;
        idx_r <= '0;
      end
      OP_PUSH: begin
        cur_r <= rd_key;
        idx_r <= '0;
      end
      OP_POP_LD: begin
        cur_r <= stk_q[StkW-1 -: SlotKeyW];
        idx_r <= CW'(stk_q[IW-1:0]) + One;
      end
      OP_E_INC: e_r <= e_r + One;
      OP_F_DEC: f_r <= f_r - One;
      OP_CP_WR: f_r <= f_r - One;
      OP_DONE: begin
        o_status_r <= status_r;
        o_fk_r <= fk_r;
        o_fp_r <= fp_r;
        o_fd_r <= fd_r;
        o_rem_r <= (cmd_r == CMD_REMOVE) ? removed_r : '0;
        o_cnt_r <= fill_r;
      end
      default: ;
    endcase
  end

  assign out_strobe = strobe_r;
  assign out_status = o_status_r;
  assign out_found_key = o_fk_r;
  assign out_found_parent = o_fp_r;
  assign out_found_data = o_fd_r;
  assign out_removed_count = o_rem_r;
  assign out_entry_count = o_cnt_r;

endmodule

/* rtl/core/keyed_table_with_cascading_delete.sv */
// Channel   Handshake            Ports
// command   start & !busy        in_command, in_entry_key, in_parent_key, in_data_handle
// result    out_strobe, 1 cycle  out_status, out_found_*, out_removed_count, out_entry_count
//
// One command at a time. Search scans the slots one by one (slot memory read is registered)
// and stops at the first hit. Remove scans the slots for each key cleared and each child
// descent, and pops the stack to resume the parent's scan. Compact moves valid entries from
// the end of the table into empty slots nearer the start. Reset clears valid bits, fill and
// stack pointer at once; no clearing pass. The result cannot be held off; busy drops as it
// appears.
module keyed_table_with_cascading_delete
  import ktcd_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_command,
  input  logic [KeyW-1:0]                      in_entry_key,
  input  logic [KeyW-1:0]                      in_parent_key,
  input  logic [HANDLE_WIDTH-1:0]              in_data_handle,
  output logic                                 out_strobe,
  output logic [1:0]                           out_status,
  output logic [SlotKeyW-1:0]                  out_found_key,
  output logic [SlotKeyW-1:0]                  out_found_parent,
  output logic [HANDLE_WIDTH-1:0]              out_found_data,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     out_removed_count,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     out_entry_count
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  ktcd_op_t    op;
  ktcd_flags_t flags;

  ktcd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .op    (op),
    .busy  (busy)
  );

  ktcd_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH),
    .IW           (IW),
    .CW           (CW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .flags             (flags),
    .in_command        (in_command),
    .in_entry_key      (in_entry_key),
    .in_parent_key     (in_parent_key),
    .in_data_handle    (in_data_handle),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_found_key     (out_found_key),
    .out_found_parent  (out_found_parent),
    .out_found_data    (out_found_data),
    .out_removed_count (out_removed_count),
    .out_entry_count   (out_entry_count)
  );

endmodule

/* tb/testbench.sv */
module testbench;
  import ktcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 64;
  localparam int CycleLimit = 100000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] fkey;
    logic [30:0] fpar;
    logic [15:0] fdata;
    logic [6:0]  removed;
    logic [6:0]  count;
  } table_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [31:0] in_entry_key;
  logic [31:0] in_parent_key;
  logic [15:0] in_data_handle;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [30:0] out_found_key;
  logic [30:0] out_found_parent;
  logic [15:0] out_found_data;
  logic [6:0]  out_removed_count;
  logic [6:0]  out_entry_count;

  keyed_table_with_cascading_delete dut (.*);

  // table shadow
  bit          tbl_valid [Depth];
  bit [31:0]   tbl_key [Depth];
  bit [31:0]   tbl_par [Depth];
  bit [15:0]   tbl_data [Depth];
  int          tbl_fill;

  table_result_t pending_results[$];
  int  errors;
  int  cycles;
  bit  allow_idle;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int fill_now();
    return (tbl_fill > Depth) ? Depth : tbl_fill;
  endfunction

  function automatic int clear_key(bit [31:0] k);
    for (int i = 0; i < fill_now(); i++) begin
      if (tbl_valid[i] && tbl_key[i] == k) begin
        tbl_valid[i] = 0;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic int remove_tree(bit [31:0] top);
    bit [31:0] key_stack [Depth];
    int        scan_stack [Depth];
    int        n, removed, scan, sp;
    bit [31:0] cur;
    bit        pushed;
    n = fill_now();
    removed = clear_key(top);
    cur = top;
    scan = 0;
    sp = 0;
    forever begin
      pushed = 0;
      while (scan < n) begin
        if (tbl_valid[scan] && tbl_par[scan] == cur && sp < Depth) begin
          key_stack[sp] = cur;
          scan_stack[sp] = scan;
          sp++;
          cur = tbl_key[scan];
          removed += clear_key(cur);
          scan = 0;
          pushed = 1;
          break;
        end
        scan++;
      end
      if (!pushed) begin
        if (sp == 0) break;
        sp--;
        cur = key_stack[sp];
        scan = scan_stack[sp] + 1;
      end
    end
    return removed;
  endfunction

  function automatic void swap_entries(int a, int b);
    bit v;
    bit [31:0] k, p;
    bit [15:0] d;
    v = tbl_valid[a]; k = tbl_key[a]; p = tbl_par[a]; d = tbl_data[a];
    tbl_valid[a] = tbl_valid[b]; tbl_key[a] = tbl_key[b];
    tbl_par[a] = tbl_par[b]; tbl_data[a] = tbl_data[b];
    tbl_valid[b] = v; tbl_key[b] = k; tbl_par[b] = p; tbl_data[b] = d;
  endfunction

  function automatic void compact_table();
    int n, e, f;
    n = fill_now();
    e = n;
    f = -1;
    for (int i = 0; i < n; i++)
      if (!tbl_valid[i]) begin
        e = i;
        break;
      end
    if (e == n) return;
    for (int i = n - 1; i >= 0; i--)
      if (tbl_valid[i]) begin
        f = i;
        break;
      end
    while (f > e) begin
      swap_entries(e, f);
      while (f > 0 && !tbl_valid[f]) f--;
      while (e < n && tbl_valid[e]) e++;
    end
    tbl_fill = e;
  endfunction

  function automatic table_result_t apply_command(logic [1:0] cmd, logic [31:0] key,
                                                  logic [31:0] par, logic [15:0] data);
    table_result_t r;
    int n;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        n = fill_now();
        if (n >= Depth) r.status = ST_FULL;
        else if ($signed(key) < 1 || $signed(par) < 0) r.status = ST_BADARG;
        else begin
          tbl_valid[n] = 1;
          tbl_key[n] = key;
          tbl_par[n] = par;
          tbl_data[n] = data;
          tbl_fill = n + 1;
        end
      end
      CMD_REMOVE: begin
        if ($signed(key) >= 1) r.removed = 7'(remove_tree(key));
      end
      CMD_SEARCH: begin
        if ($signed(key) < 1) r.status = ST_BADARG;
        else begin
          r.status = ST_NOTFOUND;
          for (int i = 0; i < fill_now(); i++)
            if (tbl_valid[i] && tbl_key[i] == key) begin
              r.status = ST_OK;
              r.fkey = tbl_key[i][30:0];
              r.fpar = tbl_par[i][30:0];
              r.fdata = tbl_data[i];
              break;
            end
        end
      end
      default: compact_table();
    endcase
    r.count = tbl_fill[6:0];
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result status=%0d", $time, out_status);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_found_key !== want.fkey ||
            out_found_parent !== want.fpar || out_found_data !== want.fdata ||
            out_removed_count !== want.removed || out_entry_count !== want.count) begin
          errors++;
          $display("%0t mismatch expected st=%0d key=%h par=%h data=%h rm=%0d cnt=%0d",
                   $time, want.status, want.fkey, want.fpar, want.fdata,
                   want.removed, want.count);
          $display("%0t          actual   st=%0d key=%h par=%h data=%h rm=%0d cnt=%0d",
                   $time, out_status, out_found_key, out_found_parent,
                   out_found_data, out_removed_count, out_entry_count);
        end
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [31:0] key, logic [31:0] par,
                           logic [15:0] data);
    start <= 1;
    in_command <= cmd;
    in_entry_key <= key;
    in_parent_key <= par;
    in_data_handle <= data;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_results.push_back(apply_command(cmd, key, par, data));
    // random idle burst; otherwise hold start for the next item
    if (allow_idle && $urandom_range(3) == 0) begin
      start <= 0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
  endtask

  task automatic test_bad_arguments();
    send_item(CMD_INSERT, 32'd0, 32'd0, 16'h1234);
    send_item(CMD_INSERT, 32'hffff_ffff, 32'd0, 16'h0);
    send_item(CMD_INSERT, 32'h8000_0000, 32'd1, 16'h0);
    send_item(CMD_INSERT, 32'd5, 32'h8000_0000, 16'hffff);
    send_item(CMD_SEARCH, 32'd0, 32'd0, 16'd0);
    send_item(CMD_SEARCH, 32'h8000_0000, 32'd0, 16'd0);
    send_item(CMD_REMOVE, 32'hffff_ffff, 32'd0, 16'd0);
  endtask

  task automatic test_insert_search();
    send_item(CMD_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
    send_item(CMD_INSERT, 32'd1, 32'd0, 16'h0000);
    send_item(CMD_SEARCH, 32'h7fff_ffff, 32'd0, 16'd0);
    send_item(CMD_SEARCH, 32'd1, 32'd0, 16'd0);
    send_item(CMD_SEARCH, 32'd2, 32'd0, 16'd0);
    send_item(CMD_COMPACT, 32'd0, 32'd0, 16'd0);
  endtask

  task automatic test_cascade();
    // tree under 10, an orphan child of absent key 20, and a parent cycle
    send_item(CMD_INSERT, 32'd10, 32'd0, 16'h00a0);
    send_item(CMD_INSERT, 32'd11, 32'd10, 16'h00b0);
    send_item(CMD_INSERT, 32'd12, 32'd11, 16'h00c0);
    send_item(CMD_INSERT, 32'd13, 32'd10, 16'h00d0);
    send_item(CMD_INSERT, 32'd21, 32'd20, 16'h0021);
    send_item(CMD_INSERT, 32'd30, 32'd31, 16'h0030);
    send_item(CMD_INSERT, 32'd31, 32'd30, 16'h0031);
    send_item(CMD_REMOVE, 32'd10, 32'd0, 16'd0);
    send_item(CMD_REMOVE, 32'd20, 32'd0, 16'd0);
    send_item(CMD_REMOVE, 32'd30, 32'd0, 16'd0);
    send_item(CMD_COMPACT, 32'd0, 32'd0, 16'd0);
    send_item(CMD_SEARCH, 32'd1, 32'd0, 16'd0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < Depth + 2; i++)
      send_item(CMD_INSERT, 32'(i % 9 + 1), 32'($urandom_range(9)), 16'($urandom));
    send_item(CMD_REMOVE, 32'd3, 32'd0, 16'd0);
    send_item(CMD_COMPACT, 32'd0, 32'd0, 16'd0);
    send_item(CMD_REMOVE, 32'd1, 32'd0, 16'd0);
    send_item(CMD_COMPACT, 32'd0, 32'd0, 16'd0);
  endtask

  task automatic test_random(int count);
    logic [1:0]  cmd;
    logic [31:0] key, par;
    int          pick;
    for (int i = 0; i < count; i++) begin
      if (i > count * 4 / 5) allow_idle = 0;
      pick = $urandom_range(99);
      if (pick < 45) cmd = CMD_INSERT;
      else if (pick < 63) cmd = CMD_REMOVE;
      else if (pick < 90) cmd = CMD_SEARCH;
      else cmd = CMD_COMPACT;
      key = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(24, 1));
      par = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(24));
      send_item(cmd, key, par, 16'($urandom));
    end
  endtask

  initial begin
    int wait_cycles;
    errors = 0;
    cycles = 0;
    allow_idle = 1;
    rst_n = 0;
    start = 0;
    in_command = CMD_INSERT;
    in_entry_key = '0;
    in_parent_key = '0;
    in_data_handle = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    test_bad_arguments();
    test_insert_search();
    test_cascade();
    test_full_table();
    test_random(1200);

    start <= 0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
